// File: design/color_ramp_stepper_assert.svh
// assertion macros for the colour ramp stepper
// used by color_ramp_stepper.sv, no other dependencies
`ifndef COLOR_RAMP_STEPPER_ASSERT_SVH
`define COLOR_RAMP_STEPPER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define CRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante implies cons");

// next-cycle implication, checked out of reset
`define CRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante implies cons next cycle");

`else

`define CRS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CRS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: design/crs_pkg.sv
// shared types and constants for the colour ramp stepper
// no dependencies; used by the channel interfaces and the top level
package crs_pkg;

    localparam int COLOR_W      = 24;
    localparam int CHAN_W       = 8;
    localparam int COUNT_W      = 11;
    localparam int CMD_W        = 2;
    localparam int STEP_LIMIT_DEF = 1500;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [CHAN_W-1:0]  CHAN_MAX   = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_FWD   = 2'd0,
        CMD_REV   = 2'd1,
        CMD_COUNT = 2'd2
    } cmd_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

endpackage

// File: design/crs_in_if.sv
// request channel of the colour ramp stepper
// depends on crs_pkg
interface crs_in_if
    import crs_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [COLOR_W-1:0]  start_color;
    logic [COLOR_W-1:0]  target_color;
    logic [COUNT_W-1:0]  step_total;

    modport source (output valid, command, start_color, target_color, step_total,
                    input ready);
    modport sink   (input valid, command, start_color, target_color, step_total,
                    output ready);
endinterface

// File: design/crs_out_if.sv
// result channel of the colour ramp stepper
// depends on crs_pkg
interface crs_out_if
    import crs_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [COLOR_W-1:0]  result_color;
    logic [COUNT_W-1:0]  step_count;

    modport source (output valid, result_color, step_count, input ready);
    modport sink   (input valid, result_color, step_count, output ready);
endinterface

// File: design/color_ramp_stepper.sv
// colour ramp stepper: top level, one shared ramp-step unit under a small sequencer
// depends on crs_pkg, crs_in_if, crs_out_if and color_ramp_stepper_assert.svh
//
//   in_ch carries command, start_color, target_color and step_total; a transfer
//   happens when valid and ready are both high. out_ch returns one result per
//   request: result_color and step_count.
//   commands 0 and 1 walk the colour forward or in reverse step_total times;
//   command 2 counts forward steps from start to target, answering 0 when the
//   colours already match or STEP_LIMIT steps pass without a match.
//   one ramp step is done per cycle by a single step unit; a request takes n
//   steps, n being step_total for commands 0 and 1 and the step count (at most
//   STEP_LIMIT) for command 2; the result shows on out_ch and in_ch is ready
//   again in the same cycle, so a new request is taken only once the last one
//   is through; a result waiting in the output register does not stop the next
//   request from being taken; if it is still not taken when the next one
//   finishes, the sequencer holds its result and in_ch stays not ready until
//   it frees.
//   reset clears the sequencer and the output valid; no clearing pass.
`include "color_ramp_stepper_assert.svh"

module color_ramp_stepper
    import crs_pkg::*;
#(
    parameter int STEP_LIMIT = STEP_LIMIT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    crs_in_if.sink      in_ch,
    crs_out_if.source   out_ch
);

    localparam int LIMIT_W = $clog2(STEP_LIMIT + 1);
    localparam int ITER_W  = (LIMIT_W > COUNT_W) ? LIMIT_W : COUNT_W;
    localparam logic [ITER_W-1:0] LIMIT_VAL = ITER_W'(STEP_LIMIT);
    localparam logic [ITER_W-1:0] SAT_VAL   = ITER_W'(COUNT_MAX);

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [COLOR_W-1:0]   color_reg, color_next;
    logic [COLOR_W-1:0]   target_reg, target_next;
    logic [COUNT_W-1:0]   total_reg, total_next;
    logic [ITER_W-1:0]    iter_reg, iter_next;

    logic                 out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0]   result_color_reg, result_color_next;
    logic [COUNT_W-1:0]   step_count_reg, step_count_next;

    // start colour kept for the count command's echo
    logic [COLOR_W-1:0]   echo_reg;

    logic                 in_fire;
    logic                 out_free;
    logic                 finished;
    logic                 load;
    logic                 reverse;
    logic [COLOR_W-1:0]   stepped;
    logic [COUNT_W-1:0]   count_val;

    // shared ramp-step unit; reverse mirrors red and blue
    always_comb
    begin
        logic [CHAN_W-1:0] r, g, b;
        logic [CHAN_W-1:0] lo, hi;
        r = color_reg[23:16];
        g = color_reg[15:8];
        b = color_reg[7:0];
        hi = reverse ? b : r;
        lo = reverse ? r : b;
        if (hi != CHAN_MAX && g == '0 && lo == '0)
        begin
            hi = hi + 1'b1;
        end
        else if (g != CHAN_MAX && hi != '0 && lo == '0)
        begin
            hi = hi - 1'b1;
            g  = g + 1'b1;
        end
        else if (lo != CHAN_MAX && g != '0 && hi == '0)
        begin
            g  = g - 1'b1;
            lo = lo + 1'b1;
        end
        else if (lo != '0)
        begin
            lo = lo - 1'b1;
        end
        else
        begin
            hi = '0;
            g  = '0;
            lo = '0;
        end
        stepped = reverse ? {lo, g, hi} : {hi, g, lo};
    end

    assign reverse  = (cmd_reg == CMD_REV);
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign load     = (state_reg == ST_RUN) && finished && out_free;

    // limit hit gives 0, otherwise the count saturates to the field width
    assign count_val = (iter_reg == LIMIT_VAL) ? '0 :
                       (iter_reg > SAT_VAL)    ? COUNT_MAX :
                                                 iter_reg[COUNT_W-1:0];

    always_comb
    begin
        case (cmd_reg)
            CMD_FWD, CMD_REV: finished = (iter_reg == ITER_W'(total_reg));
            CMD_COUNT:        finished = (color_reg == target_reg) || (iter_reg == LIMIT_VAL);
            default:          finished = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        color_next        = color_reg;
        target_next       = target_reg;
        total_next        = total_reg;
        iter_next         = iter_reg;
        out_valid_next    = out_valid_reg && !out_ch.ready;
        result_color_next = result_color_reg;
        step_count_next   = step_count_reg;
        in_ch.ready       = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next    = cmd_t'(in_ch.command);
                    color_next  = in_ch.start_color;
                    target_next = in_ch.target_color;
                    total_next  = in_ch.step_total;
                    iter_next   = '0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (finished)
                begin
                    if (out_free)
                    begin
                        out_valid_next    = 1'b1;
                        // the count command walks color_reg but answers with the start colour
                        result_color_next = (cmd_reg == CMD_COUNT) ? echo_reg : color_reg;
                        step_count_next   = (cmd_reg == CMD_COUNT) ? count_val : '0;
                        state_next        = ST_IDLE;
                    end
                end
                else
                begin
                    iter_next  = iter_reg + 1'b1;
                    color_next = stepped;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            echo_reg <= in_ch.start_color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        color_reg        <= color_next;
        target_reg       <= target_next;
        total_reg        <= total_next;
        iter_reg         <= iter_next;
        step_count_reg   <= step_count_next;
        result_color_reg <= result_color_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.result_color = result_color_reg;
    assign out_ch.step_count   = step_count_reg;

    `CRS_ASSERT_NEXT(a_accept_runs, clk, rst_n, in_fire, state_reg == ST_RUN)
    `CRS_ASSERT_NEXT(a_load_valid, clk, rst_n, load, out_valid_reg)
    `CRS_ASSERT_NEXT(a_count_only, clk, rst_n, load && cmd_reg != CMD_COUNT, step_count_reg == '0)
    `CRS_ASSERT_NOW(a_iter_bound, clk, rst_n, state_reg == ST_RUN && cmd_reg == CMD_COUNT, iter_reg <= LIMIT_VAL)

endmodule

// File: verif/color_ramp_stepper_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for color_ramp_stepper: directed then random requests
// depends on crs_pkg, crs_in_if, crs_out_if and the color_ramp_stepper rtl
module color_ramp_stepper_tb
    import crs_pkg::*;
;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int RANDOM_REQS    = 370;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 16;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [COLOR_W-1:0] start_color;
        logic [COLOR_W-1:0] target_color;
        logic [COUNT_W-1:0] step_total;
    } ramp_req_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [COUNT_W-1:0] count;
    } ramp_res_t;

    logic clk;
    logic rst_n;

    crs_in_if  in_ch ();
    crs_out_if out_ch ();

    ramp_req_t pending_reqs[$];
    ramp_res_t expected_results[$];
    ramp_req_t next_req;
    ramp_res_t oldest_result;
    int        reqs_queued;
    int        reqs_taken;
    int        quiet_cycles;
    int        fail_count;

    color_ramp_stepper DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [COLOR_W-1:0] step_forward(input logic [COLOR_W-1:0] c);
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        r = c[23:16];
        g = c[15:8];
        b = c[7:0];
        if (r != CHAN_MAX && g == '0 && b == '0)
            r = r + 1'b1;
        else if (g != CHAN_MAX && r != '0 && b == '0)
        begin
            r = r - 1'b1;
            g = g + 1'b1;
        end
        else if (b != CHAN_MAX && g != '0 && r == '0)
        begin
            g = g - 1'b1;
            b = b + 1'b1;
        end
        else if (b != '0)
            b = b - 1'b1;
        else
            return '0;
        return {r, g, b};
    endfunction

    // mirror of the forward ramp, red and blue swapped
    function automatic logic [COLOR_W-1:0] step_reverse(input logic [COLOR_W-1:0] c);
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        r = c[23:16];
        g = c[15:8];
        b = c[7:0];
        if (b != CHAN_MAX && g == '0 && r == '0)
            b = b + 1'b1;
        else if (g != CHAN_MAX && b != '0 && r == '0)
        begin
            b = b - 1'b1;
            g = g + 1'b1;
        end
        else if (r != CHAN_MAX && g != '0 && b == '0)
        begin
            g = g - 1'b1;
            r = r + 1'b1;
        end
        else if (r != '0)
            r = r - 1'b1;
        else
            return '0;
        return {r, g, b};
    endfunction

    function automatic logic [COLOR_W-1:0] walk_forward(input logic [COLOR_W-1:0] c,
                                                        input int n);
        for (int i = 0; i < n; i++)
            c = step_forward(c);
        return c;
    endfunction

    function automatic logic [COUNT_W-1:0] steps_to_target(input logic [COLOR_W-1:0] from,
                                                           input logic [COLOR_W-1:0] to);
        int n;
        n = 0;
        while (from != to && n < STEP_LIMIT_DEF)
        begin
            from = step_forward(from);
            n++;
        end
        if (n == STEP_LIMIT_DEF)
            return '0;
        if (n > int'(COUNT_MAX))
            return COUNT_MAX;
        return COUNT_W'(n);
    endfunction

    function automatic ramp_res_t predict_ramp(input ramp_req_t q);
        ramp_res_t res;
        res.color = q.start_color;
        res.count = '0;
        case (q.command)
            CMD_FWD:
                res.color = walk_forward(q.start_color, int'(q.step_total));
            CMD_REV:
                for (int i = 0; i < int'(q.step_total); i++)
                    res.color = step_reverse(res.color);
            CMD_COUNT:
                res.count = steps_to_target(q.start_color, q.target_color);
            default:
                ;
        endcase
        return res;
    endfunction

    // mostly colours already on the ramp, plus dead ends and plain noise
    function automatic logic [COLOR_W-1:0] pick_color();
        logic [CHAN_W-1:0] v;
        logic [CHAN_W-1:0] w;
        v = CHAN_W'($urandom_range(1, 255));
        w = CHAN_W'($urandom_range(1, 255));
        case ($urandom_range(7))
            0:       return COLOR_W'($urandom);
            1:       return '0;
            2:       return {v, 8'h00, 8'h00};
            3:       return {v, w, 8'h00};
            4:       return {8'h00, v, w};
            5:       return {8'h00, 8'h00, v};
            6:       return {v, CHAN_MAX, 8'h00};
            default: return {8'h00, CHAN_MAX, v};
        endcase
    endfunction

    // long walks are kept rare so the run stays short
    function automatic logic [COUNT_W-1:0] pick_steps();
        case ($urandom_range(9))
            0:       return COUNT_W'($urandom_range(2047));
            1:       return COUNT_W'($urandom_range(300));
            default: return COUNT_W'($urandom_range(40));
        endcase
    endfunction

    function automatic bit take_break();
        int pct;
        pct = (reqs_taken >= 150 && reqs_taken < 230) ? 0 : 33;
        return $urandom_range(99) < pct;
    endfunction

    task automatic queue_req(input logic [CMD_W-1:0] cmd, input logic [COLOR_W-1:0] start,
                             input logic [COLOR_W-1:0] target,
                             input logic [COUNT_W-1:0] total);
        pending_reqs.push_back({cmd, start, target, total});
        reqs_queued++;
    endtask

    task automatic queue_random_req();
        int sel;
        logic [CMD_W-1:0]   cmd;
        logic [COLOR_W-1:0] start;
        logic [COLOR_W-1:0] target;
        logic [COUNT_W-1:0] total;
        sel    = $urandom_range(99);
        start  = pick_color();
        target = COLOR_W'($urandom);
        total  = COUNT_W'($urandom);
        if (sel < 35)
        begin
            cmd   = CMD_FWD;
            total = pick_steps();
        end
        else if (sel < 70)
        begin
            cmd   = CMD_REV;
            total = pick_steps();
        end
        else if (sel < 95)
        begin
            cmd = CMD_COUNT;
            // reachable targets mostly, a random one usually runs into the limit
            if ($urandom_range(99) < 85)
                target = walk_forward(start, ($urandom_range(9) == 0) ?
                                      $urandom_range(1100) : $urandom_range(200));
        end
        else
            cmd = CMD_SPARE;
        queue_req(cmd, start, target, total);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid        <= 1'b0;
            in_ch.command      <= '0;
            in_ch.start_color  <= '0;
            in_ch.target_color <= '0;
            in_ch.step_total   <= '0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (pending_reqs.size() != 0 && !take_break())
            begin
                next_req = pending_reqs.pop_front();
                in_ch.valid        <= 1'b1;
                in_ch.command      <= next_req.command;
                in_ch.start_color  <= next_req.start_color;
                in_ch.target_color <= next_req.target_color;
                in_ch.step_total   <= next_req.step_total;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // result sink, checker and watchdog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            reqs_taken   <= 0;
            quiet_cycles <= 0;
        end
        else
        begin
            out_ch.ready <= !take_break();
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result transfer expected none actual color %h count %0d",
                             $time, out_ch.result_color, out_ch.step_count);
                    fail_count++;
                end
                else
                begin
                    oldest_result = expected_results.pop_front();
                    if (out_ch.result_color !== oldest_result.color)
                    begin
                        $display("%0t: result_color expected %h actual %h", $time,
                                 oldest_result.color, out_ch.result_color);
                        fail_count++;
                    end
                    if (out_ch.step_count !== oldest_result.count)
                    begin
                        $display("%0t: step_count expected %0d actual %0d", $time,
                                 oldest_result.count, out_ch.step_count);
                        fail_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                expected_results.push_back(predict_ramp({in_ch.command, in_ch.start_color,
                                                         in_ch.target_color,
                                                         in_ch.step_total}));
                reqs_taken <= reqs_taken + 1;
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.command      = '0;
        in_ch.start_color  = '0;
        in_ch.target_color = '0;
        in_ch.step_total   = '0;
        out_ch.ready       = 1'b0;
        reqs_queued        = 0;
        fail_count         = 0;

        // black start in both directions
        queue_req(CMD_FWD, 24'h000000, 24'hFFFFFF, 11'd1);
        queue_req(CMD_REV, 24'h000000, 24'h000000, 11'd1);
        // zero steps echo the start colour
        queue_req(CMD_FWD, 24'hA5C3E1, 24'h000000, 11'd0);
        queue_req(CMD_REV, 24'hFFFFFF, 24'hFFFFFF, 11'd0);
        // dead ends fall to black
        queue_req(CMD_FWD, 24'h80FF00, 24'h000000, 11'd1);
        queue_req(CMD_REV, 24'h00FF80, 24'h000000, 11'd1);
        // forward and reverse rules at a channel limit
        queue_req(CMD_FWD, 24'hFF0000, 24'h000000, 11'd1);
        queue_req(CMD_FWD, 24'h00FF00, 24'h000000, 11'd1);
        queue_req(CMD_FWD, 24'h0000FF, 24'h000000, 11'd1);
        queue_req(CMD_FWD, 24'hFFFFFF, 24'h000000, 11'd1);
        queue_req(CMD_REV, 24'h0000FF, 24'h000000, 11'd1);
        queue_req(CMD_REV, 24'h00FF00, 24'h000000, 11'd1);
        queue_req(CMD_REV, 24'hFF0000, 24'h000000, 11'd1);
        // longest walks
        queue_req(CMD_FWD, 24'h000000, 24'h000000, 11'd2047);
        queue_req(CMD_REV, 24'hFFFFFF, 24'hFFFFFF, 11'd2047);
        // counting: equal colours, a long reachable target, the step limit
        queue_req(CMD_COUNT, 24'h123456, 24'h123456, 11'd2047);
        queue_req(CMD_COUNT, 24'h000000, 24'h00FF00, 11'd0);
        queue_req(CMD_COUNT, 24'hFFFFFF, 24'h0000FF, 11'd5);
        queue_req(CMD_COUNT, 24'h123456, 24'h654321, 11'd0);
        queue_req(CMD_COUNT, 24'h000000, 24'hFFFFFF, 11'd0);
        // spare command code echoes the start colour
        queue_req(CMD_SPARE, 24'hFFFFFF, 24'hFFFFFF, 11'd2047);
        queue_req(CMD_SPARE, 24'h000000, 24'h000000, 11'd0);

        repeat (RANDOM_REQS)
            queue_random_req();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (reqs_taken < reqs_queued || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/crs_pkg.sv
design/crs_in_if.sv
design/crs_out_if.sv
design/color_ramp_stepper.sv
verif/color_ramp_stepper_tb.sv
